// ===== design/tme_pkg.sv =====
// ---------------------------------------------------------------------------
// tme_pkg
// shared types and codes for the tape machine execute unit
// ---------------------------------------------------------------------------
package tme_pkg;

    localparam int IP_W   = 16;
    localparam int DP_W   = 24;
    localparam int CELL_W = 8;
    localparam int OPR_W  = 16;

    // opcodes
    localparam logic [2:0] OP_OUTPUT = 3'd0;
    localparam logic [2:0] OP_INPUT  = 3'd1;
    localparam logic [2:0] OP_ADD    = 3'd2;
    localparam logic [2:0] OP_MOVE   = 3'd3;
    localparam logic [2:0] OP_JZ     = 3'd4;
    localparam logic [2:0] OP_JNZ    = 3'd5;
    localparam logic [2:0] OP_CLEAR  = 3'd6;
    localparam logic [2:0] OP_HALT   = 3'd7;

    // run status codes
    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_HALT = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // tape write request from the execute stage
    typedef struct packed {
        logic              en;
        logic [CELL_W-1:0] data;
    } tape_wr_t;

endpackage

// ===== design/tme_ram.sv =====
// ---------------------------------------------------------------------------
// tme_ram
// generic single write port ram with one registered read port
// ---------------------------------------------------------------------------
module tme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tme_tape.sv =====
// ---------------------------------------------------------------------------
// tme_tape
// tape memory with clearing pass after reset and write-to-read forwarding
// ---------------------------------------------------------------------------
module tme_tape
    import tme_pkg::*;
#(
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tape_wr_t                 wr,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [CELL_W-1:0]        rd_cell,
    output logic                     clearing
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic              clr_busy_reg;
    logic [AW-1:0]     clr_addr_reg;
    logic              fwd_hit_reg;
    logic [CELL_W-1:0] fwd_data_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;

    // clearing pass owns the write port until it ends
    always_comb
    begin
        if (clr_busy_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = wr.en;
            ram_waddr = wr_addr;
            ram_wdata = wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // same-edge write and read of one entry: take the written value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= ram_we && (ram_waddr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= ram_wdata;
    end

    tme_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign rd_cell  = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign clearing = clr_busy_reg;

endmodule

// ===== design/tape_machine_execute_unit.sv =====
// ---------------------------------------------------------------------------
// tape_machine_execute_unit
// execute unit of a byte tape machine: one start command or instruction per request
// ---------------------------------------------------------------------------
// path: a request passes the execute stage register, then the output register;
//   the last tape write is forwarded to the read of the next request
// throughput: one request per cycle while m_tready drains the output; the tape cell
//   for the next request is read at the data pointer the current request leaves
// reset: pointers, status and program_length go to zero, then a clearing pass
//   writes zero to all TAPE_DEPTH cells, one per cycle, with s_tready low
// ---------------------------------------------------------------------------
module tape_machine_execute_unit
    import tme_pkg::*;
#(
    parameter int TAPE_DEPTH = 32768
) (
    input  logic        clk,
    input  logic        rst_n,

    // configuration: program_length
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    // request side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // opcode[2:0], operand[18:3], in_byte[26:19], zero
    input  logic        s_tuser,   // command

    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // next_ip[15:0], out_byte[23:16], status[25:24], zero
    output logic        m_tuser    // out_valid
);

    localparam int AW = $clog2(TAPE_DEPTH);
    localparam logic [DP_W-1:0] DEPTH_LIMIT = DP_W'(TAPE_DEPTH);

    // architectural state
    logic [IP_W-1:0]   prog_len_reg;
    logic [IP_W-1:0]   ip_reg,  ip_next;
    logic [DP_W-1:0]   dp_reg,  dp_next;
    logic [1:0]        st_reg,  st_next;

    // execute stage
    logic              e_valid_reg;
    logic              e_cmd_reg;
    logic [2:0]        e_op_reg;
    logic [OPR_W-1:0]  e_opr_reg;
    logic [CELL_W-1:0] e_in_reg;

    // output register
    logic              o_valid_reg;
    logic [IP_W-1:0]   o_ip_reg,   o_ip_next;
    logic              o_pv_reg,   o_pv_next;
    logic [CELL_W-1:0] o_byte_reg, o_byte_next;
    logic [1:0]        o_st_reg,   o_st_next;

    logic              e_advance;
    logic              e_fire;
    logic              clearing;
    logic [CELL_W-1:0] cur_cell;
    tape_wr_t          tape_wr;
    logic              ptr_err;
    logic [IP_W-1:0]   ip_inc;

    // the execute stage moves on when the output register is free or drains
    assign e_advance = !o_valid_reg || m_tready;
    assign e_fire    = e_valid_reg && e_advance;
    assign s_tready  = !clearing && (!e_valid_reg || e_advance);

    assign ip_inc  = ip_reg + IP_W'(1);
    assign ptr_err = (dp_reg >= DEPTH_LIMIT) || (ip_reg >= prog_len_reg);

    // execute: next state, tape write and result of the request in the stage
    always_comb
    begin
        ip_next      = ip_reg;
        dp_next      = dp_reg;
        st_next      = st_reg;
        tape_wr.en   = 1'b0;
        tape_wr.data = '0;
        o_ip_next    = ip_reg;
        o_pv_next    = 1'b0;
        o_byte_next  = '0;
        o_st_next    = st_reg;
        if (e_fire)
        begin
            if (e_cmd_reg)
            begin
                // start of a new run
                ip_next   = '0;
                st_next   = ST_RUN;
                o_ip_next = '0;
                o_st_next = ST_RUN;
            end
            else if (st_reg != ST_RUN)
            begin
                // stopped: report status again, nothing changes
                o_ip_next = ip_reg;
                o_st_next = st_reg;
            end
            else if (ptr_err)
            begin
                st_next   = ST_ERR;
                o_st_next = ST_ERR;
            end
            else
            begin
                ip_next = ip_inc;
                case (e_op_reg)
                    OP_OUTPUT:
                    begin
                        o_pv_next   = 1'b1;
                        o_byte_next = cur_cell;
                    end
                    OP_INPUT:
                    begin
                        tape_wr.en   = 1'b1;
                        tape_wr.data = e_in_reg;
                    end
                    OP_ADD:
                    begin
                        tape_wr.en   = 1'b1;
                        tape_wr.data = cur_cell + e_opr_reg[CELL_W-1:0];
                    end
                    OP_MOVE:
                    begin
                        // pointer wraps modulo 2^24
                        dp_next = dp_reg + {{(DP_W-OPR_W){e_opr_reg[OPR_W-1]}}, e_opr_reg};
                    end
                    OP_JZ:
                    begin
                        if (cur_cell == '0)
                        begin
                            ip_next = e_opr_reg;
                        end
                    end
                    OP_JNZ:
                    begin
                        if (cur_cell != '0)
                        begin
                            ip_next = e_opr_reg;
                        end
                    end
                    OP_CLEAR:
                    begin
                        tape_wr.en   = 1'b1;
                        tape_wr.data = '0;
                    end
                    OP_HALT:
                    begin
                        // stay at the halt address
                        ip_next = ip_reg;
                        st_next = ST_HALT;
                    end
                    default:
                    begin
                        ip_next = ip_reg;
                    end
                endcase
                o_ip_next = ip_next;
                o_st_next = st_next;
            end
        end
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_len_reg <= '0;
            ip_reg       <= '0;
            dp_reg       <= '0;
            st_reg       <= ST_RUN;
            e_valid_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                prog_len_reg <= cfg_wr_data;
            end
            ip_reg <= ip_next;
            dp_reg <= dp_next;
            st_reg <= st_next;
            if (s_tready)
            begin
                e_valid_reg <= s_tvalid;
            end
            if (e_advance)
            begin
                o_valid_reg <= e_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            e_cmd_reg <= s_tuser;
            e_op_reg  <= s_tdata[2:0];
            e_opr_reg <= s_tdata[18:3];
            e_in_reg  <= s_tdata[26:19];
        end
        if (e_fire)
        begin
            o_ip_reg   <= o_ip_next;
            o_pv_reg   <= o_pv_next;
            o_byte_reg <= o_byte_next;
            o_st_reg   <= o_st_next;
        end
    end

    // tape: written at the current pointer, read at the pointer the next request sees
    tme_tape #(
        .DEPTH (TAPE_DEPTH)
    ) u_tape (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tape_wr),
        .wr_addr  (dp_reg[AW-1:0]),
        .rd_addr  (dp_next[AW-1:0]),
        .rd_cell  (cur_cell),
        .clearing (clearing)
    );

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {6'd0, o_st_reg, o_byte_reg, o_ip_reg};
    assign m_tuser  = o_pv_reg;

endmodule
